@@ rtl/core/zero_crossing_pulse_finder_core_defines.svh @@
// assertion macros used by the checker file
`ifndef ZERO_CROSSING_PULSE_FINDER_CORE_DEFINES_SVH
`define ZERO_CROSSING_PULSE_FINDER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ZCPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ZCPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/zcpf_pkg.sv @@
package zcpf_pkg;

  // field widths
  localparam int unsigned MaxSamplesDefault = 16384;
  localparam int unsigned SampleW   = 14;
  localparam int unsigned ValueW    = SampleW + 1;
  localparam int unsigned ChanW     = 2;
  localparam int unsigned StartW    = 14;
  localparam int unsigned WidthW    = 15;
  localparam int unsigned SumW      = 29;
  localparam int unsigned PeakW     = 14;
  localparam int unsigned CfgNarrowW = 14;
  localparam int unsigned CfgWideW  = 15;
  localparam int unsigned InTdataW  = 16;
  localparam int unsigned OutTdataW = 80;
  localparam int unsigned ApbAddrW  = 5;
  localparam int unsigned ApbDataW  = 32;
  localparam int unsigned FifoDepth = 2;

  // saturation limits of the integral
  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  // register reset values
  localparam logic [CfgNarrowW-1:0] BaselineReset    = 14'd0;
  localparam logic [CfgNarrowW-1:0] SearchStartReset = 14'd0;
  localparam logic [CfgWideW-1:0]   SearchStopReset  = 15'd10000;
  localparam logic [CfgNarrowW-1:0] AmpThreshReset   = 14'd2;
  localparam logic [CfgWideW-1:0]   WideWidthReset   = 15'd10;
  localparam logic [CfgWideW-1:0]   MinWidthReset    = 15'd5;

  // register map, word index
  typedef enum logic [2:0] {
    RegBaseline    = 3'd0,
    RegSearchStart = 3'd1,
    RegSearchStop  = 3'd2,
    RegAmpThresh   = 3'd3,
    RegWideWidth   = 3'd4,
    RegMinWidth    = 3'd5
  } reg_idx_e;

  // settings seen by the back end
  typedef struct packed {
    logic [CfgNarrowW-1:0] search_start;
    logic [CfgWideW-1:0]   search_stop;
    logic [CfgNarrowW-1:0] amp_threshold;
    logic [CfgWideW-1:0]   wide_width;
    logic [CfgWideW-1:0]   min_width;
  } cfg_t;

  // classified sample between front and back
  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     pos;
    logic                     neg;
    logic [ChanW-1:0]         chan;
    logic                     last;
  } item_t;

  // one pulse result
  typedef struct packed {
    logic                     width_ok;
    logic                     amp_over_and_wide;
    logic                     amp_over;
    logic [PeakW-1:0]         peak;
    logic signed [SumW-1:0]   integral;
    logic [WidthW-1:0]        width;
    logic [StartW-1:0]        start;
  } result_t;

endpackage

@@ rtl/core/zcpf_front.sv @@
module zcpf_front (
  input  logic [zcpf_pkg::InTdataW-1:0]   s_axis_tdata,
  input  logic [zcpf_pkg::ChanW-1:0]      s_axis_tuser,
  input  logic                            s_axis_tlast,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [zcpf_pkg::CfgNarrowW-1:0] baseline_i,
  input  logic                            fifo_full_i,
  output logic                            push_o,
  output zcpf_pkg::item_t                 item_o
);

  logic [zcpf_pkg::SampleW-1:0]       raw;
  logic signed [zcpf_pkg::ValueW-1:0] value;

  // accept whenever the queue has room
  assign s_axis_tready = ~fifo_full_i;
  assign push_o        = s_axis_tvalid & ~fifo_full_i;

  // invert against the baseline and classify the sign
  assign raw   = s_axis_tdata[zcpf_pkg::SampleW-1:0];
  assign value = $signed({1'b0, baseline_i}) - $signed({1'b0, raw});

  assign item_o.value = value;
  assign item_o.pos   = (value > 0);
  assign item_o.neg   = value[zcpf_pkg::ValueW-1];
  assign item_o.chan  = s_axis_tuser;
  assign item_o.last  = s_axis_tlast;

endmodule

@@ rtl/core/zcpf_fifo.sv @@
module zcpf_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  zcpf_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output zcpf_pkg::item_t item_o
);

  localparam int unsigned PtrW = $clog2(zcpf_pkg::FifoDepth);
  localparam int unsigned CntW = $clog2(zcpf_pkg::FifoDepth + 1);

  zcpf_pkg::item_t mem_q [zcpf_pkg::FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(zcpf_pkg::FifoDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  // pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(zcpf_pkg::FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(zcpf_pkg::FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ rtl/core/zcpf_back.sv @@
module zcpf_back #(
  parameter int unsigned MaxSamples = zcpf_pkg::MaxSamplesDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  zcpf_pkg::cfg_t           cfg_i,
  input  logic                     item_valid_i,
  input  zcpf_pkg::item_t          item_i,
  output logic                     pop_o,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output logic [zcpf_pkg::ChanW-1:0] res_chan_o,
  output zcpf_pkg::result_t        res_o
);

  localparam int unsigned IdxW = $clog2(MaxSamples + 1);
  localparam int unsigned CmpW = (IdxW > zcpf_pkg::CfgWideW) ? IdxW : zcpf_pkg::CfgWideW;

  // waveform state
  logic                           wave_begin_q, wave_begin_d;
  logic                           prev_pos_q, prev_pos_d;
  logic                           prev_neg_q, prev_neg_d;
  logic [IdxW-1:0]                idx_q, idx_d;
  logic [CmpW-1:0]                origin_q, origin_d;
  logic                           in_pulse_q, in_pulse_d;
  logic [IdxW-1:0]                start_q, start_d;
  logic signed [zcpf_pkg::SumW-1:0] sum_q, sum_d;
  logic [zcpf_pkg::PeakW-1:0]     peak_q, peak_d;

  // output stage
  logic                           res_valid_q, res_valid_d;
  logic [zcpf_pkg::ChanW-1:0]     res_chan_q;
  zcpf_pkg::result_t              res_q, res_new;

  logic                           in_range, pulse_end, pulse_begin;
  logic [CmpW-1:0]                origin, t_cmp;
  logic [IdxW-1:0]                width;
  logic signed [zcpf_pkg::SumW:0] sum_wide;
  logic signed [zcpf_pkg::SumW-1:0] sum_sat;
  logic                           amp;

  // take an item whenever the result stage can hold what it may produce
  assign pop_o       = item_valid_i & (~res_valid_q | res_ready_i);
  assign res_valid_o = res_valid_q;
  assign res_chan_o  = res_chan_q;
  assign res_o       = res_q;

  // search origin comes from the register at the start of a waveform
  assign origin   = wave_begin_q ? CmpW'(cfg_i.search_start) : origin_q;
  assign t_cmp    = CmpW'(idx_q);
  assign in_range = (idx_q < IdxW'(MaxSamples));

  assign pulse_end   = in_pulse_q & prev_pos_q & item_i.neg;
  assign pulse_begin = ~in_pulse_q & (origin < CmpW'(cfg_i.search_stop)) &
                       (idx_q != '0) & (t_cmp >= origin) & prev_neg_q & item_i.pos;

  // saturating integral update
  assign sum_wide = {sum_q[zcpf_pkg::SumW-1], sum_q} +
                    {{(zcpf_pkg::SumW + 1 - zcpf_pkg::ValueW){item_i.value[zcpf_pkg::ValueW-1]}},
                     item_i.value};
  always_comb begin
    if (sum_wide[zcpf_pkg::SumW] != sum_wide[zcpf_pkg::SumW-1]) begin
      sum_sat = sum_wide[zcpf_pkg::SumW] ? zcpf_pkg::SumMin : zcpf_pkg::SumMax;
    end else begin
      sum_sat = sum_wide[zcpf_pkg::SumW-1:0];
    end
  end

  // pulse result fields
  assign width = idx_q - start_q;
  assign amp   = (peak_q > cfg_i.amp_threshold);
  always_comb begin
    res_new.start             = zcpf_pkg::StartW'(start_q);
    res_new.width             = zcpf_pkg::WidthW'(width);
    res_new.integral          = sum_q;
    res_new.peak              = peak_q;
    res_new.amp_over          = amp;
    res_new.amp_over_and_wide = amp & (CmpW'(width) > CmpW'(cfg_i.wide_width));
    res_new.width_ok          = (CmpW'(width) >= CmpW'(cfg_i.min_width));
  end

  // pulse tracking
  always_comb begin
    wave_begin_d = wave_begin_q;
    prev_pos_d   = prev_pos_q;
    prev_neg_d   = prev_neg_q;
    idx_d        = idx_q;
    origin_d     = origin_q;
    in_pulse_d   = in_pulse_q;
    start_d      = start_q;
    sum_d        = sum_q;
    peak_d       = peak_q;
    res_valid_d  = res_valid_q & ~res_ready_i;
    if (pop_o) begin
      res_valid_d  = 1'b0;
      wave_begin_d = 1'b0;
      origin_d     = origin;
      if (in_range) begin
        if (pulse_end) begin
          res_valid_d = 1'b1;
          in_pulse_d  = 1'b0;
          origin_d    = t_cmp + 1'b1;
        end else if (in_pulse_q) begin
          sum_d = sum_sat;
          if (item_i.value > $signed({1'b0, peak_q})) begin
            peak_d = item_i.value[zcpf_pkg::PeakW-1:0];
          end
        end else if (pulse_begin) begin
          in_pulse_d = 1'b1;
          start_d    = idx_q;
          sum_d      = zcpf_pkg::SumW'(item_i.value);
          peak_d     = item_i.value[zcpf_pkg::PeakW-1:0];
        end
        prev_pos_d = item_i.pos;
        prev_neg_d = item_i.neg;
        idx_d      = idx_q + 1'b1;
      end
      // end of waveform clears the waveform state
      if (item_i.last) begin
        wave_begin_d = 1'b1;
        prev_pos_d   = 1'b0;
        prev_neg_d   = 1'b0;
        idx_d        = '0;
        origin_d     = '0;
        in_pulse_d   = 1'b0;
        start_d      = '0;
        sum_d        = '0;
        peak_d       = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_begin_q <= 1'b1;
      prev_pos_q   <= 1'b0;
      prev_neg_q   <= 1'b0;
      idx_q        <= '0;
      origin_q     <= '0;
      in_pulse_q   <= 1'b0;
      start_q      <= '0;
      sum_q        <= '0;
      peak_q       <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      wave_begin_q <= wave_begin_d;
      prev_pos_q   <= prev_pos_d;
      prev_neg_q   <= prev_neg_d;
      idx_q        <= idx_d;
      origin_q     <= origin_d;
      in_pulse_q   <= in_pulse_d;
      start_q      <= start_d;
      sum_q        <= sum_d;
      peak_q       <= peak_d;
      res_valid_q  <= res_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (pop_o && in_range && pulse_end) begin
      res_q      <= res_new;
      res_chan_q <= item_i.chan;
    end
  end

endmodule

@@ rtl/core/zero_crossing_pulse_finder_core.sv @@
// pulse finder: one sample transaction per cycle, no bubbles, unless the input stalls
// m_axis_tvalid comes from the result register: the sample that closes the pulse is
// written into the queue at the accepting edge, then read from the queue head by the
// tracking stage, which loads the result register when it pops that sample
// input stalls only when the queue is full, which follows from output back-pressure
// reset: asynchronous active low, registers return to defaults and waveform state clears
module zero_crossing_pulse_finder_core #(
  parameter int unsigned MaxSamples = zcpf_pkg::MaxSamplesDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [zcpf_pkg::InTdataW-1:0]  s_axis_tdata,  // [13:0] raw_sample
  input  logic [zcpf_pkg::ChanW-1:0]     s_axis_tuser,  // [1:0] channel
  input  logic                           s_axis_tlast,
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [13:0] pulse_start, [28:14] pulse_width, [57:29] pulse_integral,
  // [71:58] pulse_peak, [72] amp_over, [73] amp_over_and_wide, [74] width_ok
  output logic [zcpf_pkg::OutTdataW-1:0] m_axis_tdata,
  output logic [zcpf_pkg::ChanW-1:0]     m_axis_tuser,  // [1:0] pulse_channel
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [zcpf_pkg::ApbAddrW-1:0]  paddr,
  input  logic [zcpf_pkg::ApbDataW-1:0]  pwdata,
  output logic [zcpf_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);

  localparam int unsigned ResW = $bits(zcpf_pkg::result_t);

  logic [zcpf_pkg::CfgNarrowW-1:0] baseline_q;
  logic [zcpf_pkg::CfgNarrowW-1:0] search_start_q;
  logic [zcpf_pkg::CfgWideW-1:0]   search_stop_q;
  logic [zcpf_pkg::CfgNarrowW-1:0] amp_threshold_q;
  logic [zcpf_pkg::CfgWideW-1:0]   wide_width_q;
  logic [zcpf_pkg::CfgWideW-1:0]   min_width_q;

  logic                  cfg_wr;
  zcpf_pkg::reg_idx_e    reg_idx;
  zcpf_pkg::cfg_t        cfg;
  zcpf_pkg::item_t       front_item, queue_item;
  zcpf_pkg::result_t     result;
  logic                  push, fifo_full, queue_valid, pop;

  // register access
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = zcpf_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q      <= zcpf_pkg::BaselineReset;
      search_start_q  <= zcpf_pkg::SearchStartReset;
      search_stop_q   <= zcpf_pkg::SearchStopReset;
      amp_threshold_q <= zcpf_pkg::AmpThreshReset;
      wide_width_q    <= zcpf_pkg::WideWidthReset;
      min_width_q     <= zcpf_pkg::MinWidthReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        zcpf_pkg::RegBaseline:    baseline_q      <= pwdata[zcpf_pkg::CfgNarrowW-1:0];
        zcpf_pkg::RegSearchStart: search_start_q  <= pwdata[zcpf_pkg::CfgNarrowW-1:0];
        zcpf_pkg::RegSearchStop:  search_stop_q   <= pwdata[zcpf_pkg::CfgWideW-1:0];
        zcpf_pkg::RegAmpThresh:   amp_threshold_q <= pwdata[zcpf_pkg::CfgNarrowW-1:0];
        zcpf_pkg::RegWideWidth:   wide_width_q    <= pwdata[zcpf_pkg::CfgWideW-1:0];
        zcpf_pkg::RegMinWidth:    min_width_q     <= pwdata[zcpf_pkg::CfgWideW-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      zcpf_pkg::RegBaseline:    prdata = zcpf_pkg::ApbDataW'(baseline_q);
      zcpf_pkg::RegSearchStart: prdata = zcpf_pkg::ApbDataW'(search_start_q);
      zcpf_pkg::RegSearchStop:  prdata = zcpf_pkg::ApbDataW'(search_stop_q);
      zcpf_pkg::RegAmpThresh:   prdata = zcpf_pkg::ApbDataW'(amp_threshold_q);
      zcpf_pkg::RegWideWidth:   prdata = zcpf_pkg::ApbDataW'(wide_width_q);
      zcpf_pkg::RegMinWidth:    prdata = zcpf_pkg::ApbDataW'(min_width_q);
      default:                  prdata = '0;
    endcase
  end

  assign cfg.search_start  = search_start_q;
  assign cfg.search_stop   = search_stop_q;
  assign cfg.amp_threshold = amp_threshold_q;
  assign cfg.wide_width    = wide_width_q;
  assign cfg.min_width     = min_width_q;

  // front end: baseline inversion and sign classification
  zcpf_front u_front (
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .baseline_i    (baseline_q),
    .fifo_full_i   (fifo_full),
    .push_o        (push),
    .item_o        (front_item)
  );

  // decoupling queue
  zcpf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .item_o  (queue_item)
  );

  // back end: pulse tracking and result register
  zcpf_back #(
    .MaxSamples (MaxSamples)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (queue_valid),
    .item_i       (queue_item),
    .pop_o        (pop),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_chan_o   (m_axis_tuser),
    .res_o        (result)
  );

  assign m_axis_tdata = {{(zcpf_pkg::OutTdataW - ResW){1'b0}}, result};

endmodule

@@ rtl/core/zcpf_checker.sv @@
`include "zero_crossing_pulse_finder_core_defines.svh"

module zcpf_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [zcpf_pkg::OutTdataW-1:0] m_axis_tdata,
  input logic [zcpf_pkg::ChanW-1:0]     m_axis_tuser
);

  // a stalled result transaction holds its payload
  `ZCPF_ASSERT_NEXT(a_res_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // a pulse covers at least one sample
  `ZCPF_ASSERT_NOW(a_width_nonzero, m_axis_tvalid, m_axis_tdata[28:14] != 15'd0, "pulse width zero")

  // a pulse opens on a positive sample, so its peak is above zero
  `ZCPF_ASSERT_NOW(a_peak_nonzero, m_axis_tvalid, m_axis_tdata[71:58] != 14'd0, "pulse peak zero")

  // wide flag only together with the amplitude flag
  `ZCPF_ASSERT_NOW(a_wide_needs_amp, m_axis_tvalid && m_axis_tdata[73], m_axis_tdata[72], "wide flag without amplitude flag")

endmodule

bind zero_crossing_pulse_finder_core zcpf_checker u_zcpf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ test/zero_crossing_pulse_finder_core_tb.sv @@
`timescale 1ns / 100ps

import zcpf_pkg::*;

// one expected pulse, in the order of the result fields
typedef struct packed {
  logic [ChanW-1:0]       chan;
  logic [StartW-1:0]      start;
  logic [WidthW-1:0]      width;
  logic signed [SumW-1:0] integral;
  logic [PeakW-1:0]       peak;
  logic                   amp_over;
  logic                   amp_wide;
  logic                   width_ok;
} pulse_t;

// tracks the waveform as the block sees it and queues the pulses it must report
class pulse_tracker;
  localparam int IntegralMax = (1 << (SumW - 1)) - 1;
  localparam int IntegralMin = -(1 << (SumW - 1));

  // register copies
  logic [CfgNarrowW-1:0] baseline, search_start, amp_threshold;
  logic [CfgWideW-1:0]   search_stop, wide_width, min_width;

  // waveform state
  int prev_value, sample_index, search_origin, start_index, running_sum, running_peak;
  bit in_pulse, wave_begin;

  pulse_t pending_pulses[$];
  int errors, samples, waves, pulses_seen;

  function new();
    baseline      = BaselineReset;
    search_start  = SearchStartReset;
    search_stop   = SearchStopReset;
    amp_threshold = AmpThreshReset;
    wide_width    = WideWidthReset;
    min_width     = MinWidthReset;
    clear_wave();
  endfunction

  function void clear_wave();
    prev_value    = 0;
    sample_index  = 0;
    search_origin = 0;
    in_pulse      = 1'b0;
    start_index   = 0;
    running_sum   = 0;
    running_peak  = 0;
    wave_begin    = 1'b1;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] value);
    case (idx)
      RegBaseline:    baseline      = value[CfgNarrowW-1:0];
      RegSearchStart: search_start  = value[CfgNarrowW-1:0];
      RegSearchStop:  search_stop   = value[CfgWideW-1:0];
      RegAmpThresh:   amp_threshold = value[CfgNarrowW-1:0];
      RegWideWidth:   wide_width    = value[CfgWideW-1:0];
      RegMinWidth:    min_width     = value[CfgWideW-1:0];
      default: ;
    endcase
  endfunction

  function int clamp_sum(int a, int b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > IntegralMax) s = IntegralMax;
    if (s < IntegralMin) s = IntegralMin;
    return int'(s);
  endfunction

  // one accepted sample transaction
  function void take_sample(logic [SampleW-1:0] raw, logic [ChanW-1:0] chan, logic last);
    int v, width;
    pulse_t p;
    samples++;
    if (wave_begin) begin
      search_origin = int'(search_start);
      wave_begin = 1'b0;
    end
    // samples past the waveform limit are dropped
    if (sample_index < MaxSamplesDefault) begin
      v = int'(baseline) - int'(raw);
      if (in_pulse) begin
        if (prev_value > 0 && v < 0) begin
          width      = sample_index - start_index;
          p.chan     = chan;
          p.start    = start_index[StartW-1:0];
          p.width    = width[WidthW-1:0];
          p.integral = running_sum[SumW-1:0];
          p.peak     = running_peak[PeakW-1:0];
          p.amp_over = running_peak > int'(amp_threshold);
          p.amp_wide = p.amp_over && width > int'(wide_width);
          p.width_ok = width >= int'(min_width);
          pending_pulses.push_back(p);
          in_pulse = 1'b0;
          search_origin = sample_index + 1;
        end else begin
          running_sum = clamp_sum(running_sum, v);
          if (v > running_peak) running_peak = v;
        end
      end else if (search_origin < int'(search_stop) && sample_index >= 1 &&
                   sample_index >= search_origin && prev_value < 0 && v > 0) begin
        in_pulse     = 1'b1;
        start_index  = sample_index;
        running_sum  = clamp_sum(0, v);
        running_peak = v;
      end
      prev_value = v;
      sample_index++;
    end
    if (last) begin
      waves++;
      clear_wave();
    end
  endfunction

  function void compare_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // one accepted result transaction
  function void match_pulse(logic [OutTdataW-1:0] data, logic [ChanW-1:0] chan);
    result_t got;
    pulse_t want;
    got = data[$bits(result_t)-1:0];
    if (pending_pulses.size() == 0) begin
      $error("pulse result with none pending: start %0d width %0d", got.start, got.width);
      errors++;
      return;
    end
    want = pending_pulses.pop_front();
    pulses_seen++;
    compare_field("pulse_channel", want.chan, chan);
    compare_field("pulse_start", want.start, got.start);
    compare_field("pulse_width", want.width, got.width);
    compare_field("pulse_integral", want.integral, got.integral);
    compare_field("pulse_peak", want.peak, got.peak);
    compare_field("amp_over", want.amp_over, got.amp_over);
    compare_field("amp_over_and_wide", want.amp_wide, got.amp_over_and_wide);
    compare_field("width_ok", want.width_ok, got.width_ok);
  endfunction
endclass

module zero_crossing_pulse_finder_core_tb;

  localparam int BacklogCycles = 300;
  localparam int SettleCycles  = 8;
  localparam int DrainLimit    = 20000;
  localparam logic [2:0] RegUnmapped = 3'd7;

  typedef enum {LevelNeg, LevelPos, LevelZero} level_e;

  logic                  clk_i, rst_ni;
  logic                  s_axis_tvalid, s_axis_tready, s_axis_tlast;
  logic [InTdataW-1:0]   s_axis_tdata;
  logic [ChanW-1:0]      s_axis_tuser;
  logic                  m_axis_tvalid, m_axis_tready;
  logic [OutTdataW-1:0]  m_axis_tdata;
  logic [ChanW-1:0]      m_axis_tuser;
  logic                  psel, penable, pwrite, pready;
  logic [ApbAddrW-1:0]   paddr;
  logic [ApbDataW-1:0]   pwdata, prdata;

  pulse_tracker sb;
  int  cur_baseline;
  int  settings_used;
  bit  steady;
  bit  hold_request;

  zero_crossing_pulse_finder_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

  // transaction monitor on both streams
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.take_sample(s_axis_tdata[SampleW-1:0], s_axis_tuser, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready)
        sb.match_pulse(m_axis_tdata, m_axis_tuser);
    end
  end

  // mostly short stalls, now and then a long one
  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int gap_len();
    if (steady || $urandom_range(0, 99) < 55) return 0;
    return stall_len();
  endfunction

  // result sink with random back-pressure and one-off long hold-off
  initial begin
    int hold;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (BacklogCycles) @(posedge clk_i);
      end else if (steady || $urandom_range(0, 99) < 65) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        hold = stall_len();
        repeat (hold) @(posedge clk_i);
      end
    end
  end

  // raw sample giving an inverted value of the wanted sign
  function automatic logic [SampleW-1:0] pick_raw(level_e lvl);
    int b, span, r;
    b = cur_baseline;
    r = $urandom_range(0, 9);
    if (lvl == LevelPos && b > 0) begin
      span = (b < 40) ? b : 40;
      if (r < 7) return SampleW'(b - int'($urandom_range(1, span)));
      if (r < 9) return SampleW'($urandom_range(0, b - 1));
      return '0;
    end
    if (lvl == LevelNeg && b < 16383) begin
      span = (16383 - b < 40) ? 16383 - b : 40;
      if (r < 7) return SampleW'(b + int'($urandom_range(1, span)));
      if (r < 9) return SampleW'($urandom_range(b + 1, 16383));
      return '1;
    end
    return SampleW'(b);
  endfunction

  task automatic send_sample(logic [SampleW-1:0] raw, logic [ChanW-1:0] chan, logic last);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InTdataW'(raw);
    s_axis_tuser  <= chan;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_level(int v, logic [ChanW-1:0] chan, logic last);
    send_sample(SampleW'(cur_baseline - v), chan, last);
  endtask

  // waveform of random sign runs, or plain noise
  task automatic send_wave(int len, bit noise);
    int i, left, r;
    level_e lvl;
    logic [SampleW-1:0] raw;
    left = 0;
    lvl = LevelZero;
    for (i = 0; i < len; i++) begin
      if (left == 0) begin
        r = $urandom_range(0, 99);
        lvl = (r < 45) ? LevelPos : (r < 85) ? LevelNeg : LevelZero;
        left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 8);
      end
      raw = noise ? SampleW'($urandom_range(0, 16383)) : pick_raw(lvl);
      left--;
      send_sample(raw, ChanW'($urandom_range(0, 3)), i == len - 1);
    end
  endtask

  // back-to-back register writes, psel stays up until released
  task automatic apb_write(logic [2:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, value);
  endtask

  task automatic apb_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(int b, int start, int stop, int amp, int wide, int minw);
    apb_write(RegBaseline, b);
    apb_write(RegSearchStart, start);
    apb_write(RegSearchStop, stop);
    apb_write(RegAmpThresh, amp);
    apb_write(RegWideWidth, wide);
    apb_write(RegMinWidth, minw);
    cur_baseline = b;
    settings_used++;
  endtask

  // wait for every pending pulse, then let the pipeline settle
  task automatic wait_drained();
    int n;
    s_axis_tvalid <= 1'b0;
    n = 0;
    while (sb.pending_pulses.size() != 0 && n < DrainLimit) begin
      @(posedge clk_i);
      n++;
    end
    if (sb.pending_pulses.size() != 0) begin
      $error("%0d pulses never reported", sb.pending_pulses.size());
      sb.errors++;
      sb.pending_pulses.delete();
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(int b, int start, int stop, int amp, int wide, int minw,
                           bit calm, int items, bit backlog);
    int sent, len, r;
    set_config(b, start, stop, amp, wide, minw);
    apb_release();
    steady = calm;
    if (backlog) hold_request = 1'b1;
    sent = 0;
    while (sent < items) begin
      r = $urandom_range(0, 99);
      len = (r < 10) ? $urandom_range(1, 4) :
            (r < 90) ? $urandom_range(20, 120) : $urandom_range(150, 400);
      // keep the phase close to its sample budget
      if (len > items - sent) len = items - sent;
      send_wave(len, $urandom_range(0, 9) == 0);
      sent += len;
    end
    wait_drained();
  endtask

  initial begin
    sb = new();
    cur_baseline  = int'(BaselineReset);
    settings_used = 0;
    steady        = 1'b0;
    hold_request  = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: zero baseline, nothing can go positive
    send_sample('0, 2'd0, 1'b0);
    send_sample('1, 2'd3, 1'b0);
    send_sample(14'd100, 2'd1, 1'b1);
    wait_drained();

    // mid baseline, writes to an unmapped register must be dropped
    set_config(8192, 0, 16384, 100, 2, 2);
    apb_write(RegUnmapped, 32'hFFFF_FFFF);
    apb_release();

    // positive first sample, pulse through zero and a dip, full-scale swings,
    // single-sample pulse, pulse left open at the end of the waveform
    send_level(100, 2'd0, 1'b0);
    send_level(-5, 2'd1, 1'b0);
    send_level(1, 2'd2, 1'b0);
    send_level(0, 2'd3, 1'b0);
    send_level(-3, 2'd0, 1'b0);
    send_level(8192, 2'd1, 1'b0);
    send_level(7, 2'd2, 1'b0);
    send_level(-8191, 2'd3, 1'b0);
    send_level(4, 2'd0, 1'b0);
    send_level(-1, 2'd1, 1'b0);
    send_level(-2, 2'd2, 1'b0);
    send_level(9, 2'd3, 1'b0);
    send_level(9, 2'd0, 1'b1);
    wait_drained();

    // crossing before the search origin is skipped, pulse closed by the last sample
    apb_write(RegSearchStart, 3);
    apb_release();
    send_level(-1, 2'd1, 1'b0);
    send_level(2, 2'd2, 1'b0);
    send_level(-1, 2'd3, 1'b0);
    send_level(2, 2'd0, 1'b0);
    send_level(-1, 2'd1, 1'b0);
    send_level(2, 2'd2, 1'b0);
    send_level(3, 2'd3, 1'b0);
    send_level(-1, 2'd0, 1'b1);
    wait_drained();

    // random waveforms across a sweep of settings
    run_phase(8192, 0, 16384, 0, 0, 0, 1'b0, 300, 1'b1);
    run_phase(1000, 20, 16384, 16383, 16384, 16384, 1'b1, 250, 1'b0);
    run_phase(12000, 0, 40, 100, 3, 2, 1'b0, 250, 1'b0);
    run_phase(5000, 16383, 0, 50, 8, 6, 1'b0, 100, 1'b0);
    run_phase(0, 0, 10000, 2, 10, 5, 1'b0, 60, 1'b0);
    run_phase(16383, 0, 16384, 2, 10, 5, 1'b0, 60, 1'b0);
    run_phase(3000, 3, 16384, 500, 6, 3, 1'b0, 400, 1'b1);
    run_phase(9000, 7, 16384, 200, 12, 4, 1'b1, 300, 1'b0);

    $display("run covered %0d samples in %0d waveforms over %0d register settings",
             sb.samples, sb.waves, settings_used);
    $display("%0d pulse results compared field by field, %0d mismatches",
             sb.pulses_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ zero_crossing_pulse_finder_core.f @@
+incdir+rtl/core
rtl/core/zcpf_pkg.sv
rtl/core/zcpf_front.sv
rtl/core/zcpf_fifo.sv
rtl/core/zcpf_back.sv
rtl/core/zero_crossing_pulse_finder_core.sv
rtl/core/zcpf_checker.sv
test/zero_crossing_pulse_finder_core_tb.sv
